FILE: src/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Shared types and constants for the open-addressing hash set.
// ----------------------------------------------------------------------------
package ohs_pkg;

    localparam int KEY_W   = 64;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 11;
    localparam int IN_W    = 72;   // op + key, padded to bytes
    localparam int OUT_W   = 16;   // status + found + count, padded to bytes

    localparam logic [KEY_W-1:0] HASH_MUL  = 64'd73;
    localparam int               HASH_STEP = 5009;

    // slot values with a special meaning
    localparam logic [KEY_W-1:0] SLOT_EMPTY = 64'd0;
    localparam logic [KEY_W-1:0] SLOT_TOMB  = 64'd1;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RES_DONE      = 3'd0,
        RES_PRESENT   = 3'd1,
        RES_NOT_FOUND = 3'd2,
        RES_RESERVED  = 3'd3,
        RES_FULL      = 3'd4
    } res_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_HASH,
        S_PROBE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;         // take the input item
        logic clr_step;     // zero one slot of the sweep
        logic probe_start;  // load home slot, restart probe
        logic probe_step;   // issue one read, check the previous one
        logic finish;       // commit result and load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_done;
        logic probe_done;
        logic op_clear;
        logic reserved;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: src/ohs_hash.sv
// ----------------------------------------------------------------------------
// ohs_hash
// Home slot unit: (key * 73 mod 2^64) mod TABLE_DEPTH.
// ----------------------------------------------------------------------------
module ohs_hash #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ohs_pkg::KEY_W-1:0]    key,
    output logic                         done,
    output logic [$clog2(TABLE_DEPTH)-1:0] home
);

    localparam int SW    = $clog2(TABLE_DEPTH);
    localparam bit IS_P2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam int NIB   = 4;
    localparam int STEPS = ohs_pkg::KEY_W / NIB;
    localparam int CW    = $clog2(STEPS);
    localparam logic [SW:0]   DEPTH_W   = (SW+1)'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

    logic [ohs_pkg::KEY_W-1:0] prod_reg;
    logic [SW-1:0]             rem_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    // shift four product bits into the remainder, reducing after each bit
    function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] r,
                                               input logic [NIB-1:0] nib);
        logic [SW:0]   t;
        logic [SW-1:0] acc;
        acc = r;
        for (int i = NIB - 1; i >= 0; i--)
        begin
            t = {acc, nib[i]};
            if (t >= DEPTH_W)
            begin
                t = t - DEPTH_W;
            end
            acc = t[SW-1:0];
        end
        return acc;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (IS_P2 || cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // 73 = 64 + 8 + 1, wraps at 64 bits
            prod_reg <= key + (key << 3) + (key << 6);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (IS_P2)
            begin
                rem_reg <= prod_reg[SW-1:0];
            end
            else
            begin
                rem_reg  <= mod_step(rem_reg, prod_reg[ohs_pkg::KEY_W-1 -: NIB]);
                prod_reg <= prod_reg << NIB;
            end
        end
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

FILE: src/ohs_dp.sv
// ----------------------------------------------------------------------------
// ohs_dp
// Datapath: slot memory, probe walker, member count and result register.
// ----------------------------------------------------------------------------
module ohs_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ohs_pkg::ctrl_cmd_t         cmd,
    output ohs_pkg::ctrl_sts_t         sts,
    input  logic [ohs_pkg::IN_W-1:0]   in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ohs_pkg::OUT_W-1:0]  out_data
);

    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = ohs_pkg::COUNT_W;
    localparam logic [SW:0]   DEPTH_W = (SW+1)'(TABLE_DEPTH);
    localparam logic [SW:0]   STEP_W  = (SW+1)'(ohs_pkg::HASH_STEP % TABLE_DEPTH);
    localparam logic [SW-1:0] LAST_W  = SW'(TABLE_DEPTH - 1);

    logic [ohs_pkg::KEY_W-1:0] slot_mem [TABLE_DEPTH];
    logic [ohs_pkg::KEY_W-1:0] rd_data_reg;

    ohs_pkg::op_t              op_reg;
    logic [ohs_pkg::KEY_W-1:0] key_reg;
    logic                      reserved_reg;

    logic [SW-1:0] clr_addr_reg;
    logic [SW-1:0] slot_reg;
    logic [SW-1:0] cmp_slot_reg;
    logic [SW-1:0] where_reg;
    logic [SW-1:0] chk_reg;
    logic          rd_valid_reg;
    logic          hit_reg;
    logic          empty_reg;
    logic          probe_done_reg;
    logic [LW-1:0] live_reg;

    logic                     out_valid_reg;
    ohs_pkg::res_t            out_status_reg;
    logic                     out_found_reg;
    logic [CW-1:0]            out_count_reg;

    logic                      hash_done;
    logic [SW-1:0]             home;
    logic [SW:0]               slot_sum;
    logic [SW-1:0]             slot_next;
    ohs_pkg::res_t             res_status;
    logic                      res_write;
    logic [ohs_pkg::KEY_W-1:0] res_wdata;
    logic [LW-1:0]             live_next;
    logic [LW+CW-1:0]          live_ext;
    logic                      mem_we;
    logic [SW-1:0]             mem_wa;
    logic [ohs_pkg::KEY_W-1:0] mem_wd;

    ohs_hash #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .key   (in_data[ohs_pkg::OP_W +: ohs_pkg::KEY_W]),
        .done  (hash_done),
        .home  (home)
    );

    // probe stride, kept below the depth
    always_comb
    begin
        slot_sum = {1'b0, slot_reg} + STEP_W;
        if (slot_sum >= DEPTH_W)
        begin
            slot_sum = slot_sum - DEPTH_W;
        end
        slot_next = slot_sum[SW-1:0];
    end

    // result of the finished request
    always_comb
    begin
        res_status = ohs_pkg::RES_DONE;
        res_write  = 1'b0;
        res_wdata  = key_reg;
        live_next  = live_reg;
        if (op_reg == ohs_pkg::OP_CLEAR)
        begin
            live_next = '0;
        end
        else if (reserved_reg)
        begin
            res_status = ohs_pkg::RES_RESERVED;
        end
        else
        begin
            case (op_reg)
                ohs_pkg::OP_ADD:
                begin
                    if (hit_reg)
                    begin
                        res_status = ohs_pkg::RES_PRESENT;
                    end
                    else if (empty_reg)
                    begin
                        res_write = 1'b1;
                        live_next = live_reg + 1'b1;
                    end
                    else
                    begin
                        res_status = ohs_pkg::RES_FULL;
                    end
                end
                ohs_pkg::OP_REMOVE:
                begin
                    if (hit_reg)
                    begin
                        res_write = 1'b1;
                        res_wdata = ohs_pkg::SLOT_TOMB;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        res_status = ohs_pkg::RES_NOT_FOUND;
                    end
                end
                ohs_pkg::OP_CONTAINS:
                begin
                    if (!hit_reg)
                    begin
                        res_status = ohs_pkg::RES_NOT_FOUND;
                    end
                end
                default:
                begin
                    res_status = ohs_pkg::RES_DONE;
                end
            endcase
        end
        live_ext = {{CW{1'b0}}, live_next};
    end

    assign mem_we = cmd.clr_step || (cmd.finish && res_write);
    assign mem_wa = cmd.clr_step ? clr_addr_reg : where_reg;
    assign mem_wd = cmd.clr_step ? ohs_pkg::SLOT_EMPTY : res_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= slot_mem[slot_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            chk_reg        <= '0;
            hit_reg        <= 1'b0;
            empty_reg      <= 1'b0;
            probe_done_reg <= 1'b0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if (cmd.probe_start)
            begin
                rd_valid_reg   <= 1'b0;
                chk_reg        <= '0;
                hit_reg        <= 1'b0;
                empty_reg      <= 1'b0;
                probe_done_reg <= 1'b0;
            end
            else if (cmd.probe_step && !probe_done_reg)
            begin
                rd_valid_reg <= 1'b1;
                if (rd_valid_reg)
                begin
                    chk_reg <= chk_reg + 1'b1;
                    if (rd_data_reg == key_reg)
                    begin
                        hit_reg        <= 1'b1;
                        probe_done_reg <= 1'b1;
                    end
                    else if (rd_data_reg == ohs_pkg::SLOT_EMPTY)
                    begin
                        empty_reg      <= 1'b1;
                        probe_done_reg <= 1'b1;
                    end
                    else if (chk_reg == LAST_W)
                    begin
                        probe_done_reg <= 1'b1;
                    end
                end
            end

            if (cmd.finish)
            begin
                live_reg      <= live_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= ohs_pkg::op_t'(in_data[ohs_pkg::OP_W-1:0]);
            key_reg      <= in_data[ohs_pkg::OP_W +: ohs_pkg::KEY_W];
            reserved_reg <= in_data[ohs_pkg::OP_W+1 +: ohs_pkg::KEY_W-1] == '0;
        end
        if (cmd.probe_start)
        begin
            slot_reg <= home;
        end
        else if (cmd.probe_step && !probe_done_reg)
        begin
            slot_reg     <= slot_next;
            cmp_slot_reg <= slot_reg;
            if (rd_valid_reg)
            begin
                where_reg <= cmp_slot_reg;
            end
        end
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_found_reg  <= (op_reg != ohs_pkg::OP_CLEAR) && !reserved_reg && hit_reg;
            out_count_reg  <= live_ext[CW-1:0];
        end
    end

    assign sts.clr_last   = clr_addr_reg == LAST_W;
    assign sts.hash_done  = hash_done;
    assign sts.probe_done = probe_done_reg;
    assign sts.op_clear   = op_reg == ohs_pkg::OP_CLEAR;
    assign sts.reserved   = reserved_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {1'b0, out_count_reg, out_found_reg, out_status_reg};

endmodule

FILE: src/ohs_ctrl.sv
// ----------------------------------------------------------------------------
// ohs_ctrl
// Request sequencer: clearing sweep, hashing, probing and result commit.
// ----------------------------------------------------------------------------
module ohs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output ohs_pkg::ctrl_cmd_t cmd,
    input  ohs_pkg::ctrl_sts_t sts
);

    ohs_pkg::state_t state_reg;
    ohs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ohs_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ohs_pkg::S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ohs_pkg::S_IDLE;
                end
            end
            ohs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ohs_pkg::S_DISPATCH;
                end
            end
            ohs_pkg::S_DISPATCH:
            begin
                if (sts.op_clear)
                begin
                    state_next = ohs_pkg::S_CLEAR;
                end
                else if (sts.reserved)
                begin
                    state_next = ohs_pkg::S_RESULT;
                end
                else
                begin
                    state_next = ohs_pkg::S_HASH;
                end
            end
            ohs_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ohs_pkg::S_RESULT;
                end
            end
            ohs_pkg::S_HASH:
            begin
                if (sts.hash_done)
                begin
                    cmd.probe_start = 1'b1;
                    state_next      = ohs_pkg::S_PROBE;
                end
            end
            ohs_pkg::S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = ohs_pkg::S_RESULT;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end
            ohs_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ohs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ohs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/open_address_hash_set.sv
// ----------------------------------------------------------------------------
// open_address_hash_set
// Set of 64-bit keys in a fixed open-addressing table with tombstones.
// ----------------------------------------------------------------------------
//
//  channel  | dir | width | contents (low bit first)
//  ---------+-----+-------+------------------------------------------------
//  s_axis   | in  |  72   | op[1:0], key[65:2], zero pad
//  m_axis   | out |  16   | status[2:0], found[3], member_count[14:4], pad
//
// One item is in work at a time. An item passes through accept, dispatch,
// home slot hash (4 bits per cycle for depths that are not a power of two),
// probe walk (one memory read per cycle) and commit. A reserved key skips
// hash and probe; clear sweeps the slot memory instead. After reset a sweep
// zeroes the slot memory with s_axis_tready low. A result waits in the output
// register while the next item is accepted; only the commit step stalls on
// m_axis_tready.
//
module open_address_hash_set #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ohs_pkg::IN_W-1:0]   s_axis_tdata,   // op, key, pad
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ohs_pkg::OUT_W-1:0]  m_axis_tdata    // status, found, member_count, pad
);

    ohs_pkg::ctrl_cmd_t cmd;
    ohs_pkg::ctrl_sts_t sts;

    // sequencer: owns the input handshake
    ohs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: slot memory, probe walk, count and output register
    ohs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the open-addressing hash set. A tracker keeps its
// own copy of the slot table and the member count, works out the reply to
// every request the block takes, and compares each reply field by field.
// Stimulus: a short directed run (reserved keys, home-slot collisions,
// tombstones, clear), random traffic over a small colliding key pool, and a
// run that fills every slot so that add reports full and lookups walk the
// whole table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_DEPTH = 1024;
    localparam int POOL_SIZE   = 24;
    localparam int POOL_ITEMS  = 560;
    localparam int AFTER_FULL  = 60;
    localparam int STALL_LIMIT = 20000;   // cycles with no item moving

    typedef enum {
        PROBE_HIT,
        PROBE_EMPTY,
        PROBE_LIMIT
    } probe_end_t;

    typedef struct packed {
        ohs_pkg::res_t               status;
        logic                        found;
        logic [ohs_pkg::COUNT_W-1:0] count;
    } reply_t;

    // ------------------------------------------------------------------------
    // tracker: shadow slot table and the queue of replies still owed
    // ------------------------------------------------------------------------
    class hash_set_tracker;
        logic [ohs_pkg::KEY_W-1:0] slots [TABLE_DEPTH];
        int                        live;
        int                        empty_slots;
        int                        checked;
        int                        errors;
        reply_t                    pending_replies [$];

        function new();
            wipe();
            checked = 0;
            errors  = 0;
        endfunction

        function void wipe();
            foreach (slots[i])
                slots[i] = ohs_pkg::SLOT_EMPTY;
            live        = 0;
            empty_slots = TABLE_DEPTH;
        endfunction

        // walk the probe path: home slot is the low bits of key*73,
        // every further step adds HASH_STEP modulo the depth
        function probe_end_t walk(logic [ohs_pkg::KEY_W-1:0] key, output int where);
            logic [ohs_pkg::KEY_W-1:0] prod;
            int                        s;
            prod  = key * ohs_pkg::HASH_MUL;
            s     = int'(prod % 64'(TABLE_DEPTH));
            where = 0;
            for (int n = 0; n < TABLE_DEPTH; n++)
            begin
                if (slots[s] == key)
                begin
                    where = s;
                    return PROBE_HIT;
                end
                if (slots[s] == ohs_pkg::SLOT_EMPTY)
                begin
                    where = s;
                    return PROBE_EMPTY;
                end
                s = (s + ohs_pkg::HASH_STEP) % TABLE_DEPTH;
            end
            return PROBE_LIMIT;
        endfunction

        function void note_request(ohs_pkg::op_t op, logic [ohs_pkg::KEY_W-1:0] key);
            reply_t     r;
            probe_end_t pe;
            int         where;
            r.status = ohs_pkg::RES_DONE;
            r.found  = 1'b0;
            if (op == ohs_pkg::OP_CLEAR)
                wipe();
            else if (key == ohs_pkg::SLOT_EMPTY || key == ohs_pkg::SLOT_TOMB)
                r.status = ohs_pkg::RES_RESERVED;
            else
            begin
                pe      = walk(key, where);
                r.found = (pe == PROBE_HIT);
                case (op)
                    ohs_pkg::OP_ADD:
                    begin
                        if (pe == PROBE_HIT)
                            r.status = ohs_pkg::RES_PRESENT;
                        else if (pe == PROBE_EMPTY)
                        begin
                            // tombstones are never reused, only empty slots
                            slots[where] = key;
                            live++;
                            empty_slots--;
                        end
                        else
                            r.status = ohs_pkg::RES_FULL;
                    end
                    ohs_pkg::OP_REMOVE:
                    begin
                        if (pe == PROBE_HIT)
                        begin
                            slots[where] = ohs_pkg::SLOT_TOMB;
                            if (live > 0)
                                live--;
                        end
                        else
                            r.status = ohs_pkg::RES_NOT_FOUND;
                    end
                    default:
                    begin
                        if (pe != PROBE_HIT)
                            r.status = ohs_pkg::RES_NOT_FOUND;
                    end
                endcase
            end
            r.count = ohs_pkg::COUNT_W'(live);
            pending_replies.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch on reply %0d: %s", $time, checked, msg);
        endtask

        task check_reply(logic [ohs_pkg::OUT_W-1:0] data);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                report($sformatf("reply %h with none outstanding", data));
                return;
            end
            want = pending_replies.pop_front();
            if (data[2:0] !== want.status)
                report($sformatf("status %0d, expected %s", data[2:0], want.status.name()));
            if (data[3] !== want.found)
                report($sformatf("found %b, expected %b", data[3], want.found));
            if (data[14:4] !== want.count)
                report($sformatf("member_count %0d, expected %0d", data[14:4], want.count));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, bus signals
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [ohs_pkg::IN_W-1:0]   s_axis_tdata = '0;     // op, key, pad
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [ohs_pkg::OUT_W-1:0]  m_axis_tdata;          // status, found, member_count, pad

    bit                steady = 1'b0;         // no idling on either side while set

    hash_set_tracker   tracker = new();

    always #6 clk = ~clk;

    open_address_hash_set #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ohs_pkg::KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // present one request, hold it until taken, then maybe go idle
    task automatic send_request(ohs_pkg::op_t op, logic [ohs_pkg::KEY_W-1:0] key);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, key, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_request(op, key);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random back-pressure
    initial
    begin : reply_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_reply(m_axis_tdata);
    end

    // ends the run if no item moves on either side for too long; the
    // longest legal quiet stretch is a full-table walk or the reset sweep
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
        $display("** open_address_hash_set: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [ohs_pkg::KEY_W-1:0] chain;
        logic [ohs_pkg::KEY_W-1:0] key;
        logic [ohs_pkg::KEY_W-1:0] pool [POOL_SIZE];
        logic [ohs_pkg::KEY_W-1:0] members [$];
        ohs_pkg::op_t              op;
        int                        roll;
        int                        idx;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: reserved keys, collisions, tombstones, clear ---
        chain = 64'h0123_4567_89AB_CDEF;
        send_request(ohs_pkg::OP_CONTAINS, 64'd2);                // empty table
        send_request(ohs_pkg::OP_REMOVE, 64'd3);
        send_request(ohs_pkg::OP_ADD, 64'd2);
        send_request(ohs_pkg::OP_ADD, 64'd2);                     // already present
        send_request(ohs_pkg::OP_CONTAINS, 64'd2);
        send_request(ohs_pkg::OP_ADD, 64'd0);                     // reserved keys
        send_request(ohs_pkg::OP_REMOVE, 64'd1);
        send_request(ohs_pkg::OP_CONTAINS, 64'd0);
        send_request(ohs_pkg::OP_ADD, '1);                        // key*73 wraps
        send_request(ohs_pkg::OP_ADD, 64'h8000_0000_0000_0000);
        // keys equal modulo the depth share a home slot
        send_request(ohs_pkg::OP_ADD, chain);
        send_request(ohs_pkg::OP_ADD, chain + 64'h400);
        send_request(ohs_pkg::OP_ADD, chain + 64'h800);
        send_request(ohs_pkg::OP_REMOVE, chain + 64'h400);        // tombstone mid-chain
        send_request(ohs_pkg::OP_CONTAINS, chain + 64'h800);      // walks past it
        send_request(ohs_pkg::OP_CONTAINS, chain + 64'h400);
        send_request(ohs_pkg::OP_ADD, chain + 64'h400);           // lands after the chain
        send_request(ohs_pkg::OP_REMOVE, chain);
        send_request(ohs_pkg::OP_REMOVE, chain);
        send_request(ohs_pkg::OP_CONTAINS, '1);
        send_request(ohs_pkg::OP_CLEAR, '1);
        send_request(ohs_pkg::OP_CONTAINS, 64'd2);
        send_request(ohs_pkg::OP_CLEAR, 64'd1);                   // clear ignores the key
        send_request(ohs_pkg::OP_ADD, chain);

        // --- random traffic over a small pool, four keys per home slot ---
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = (i % 4 == 0) ? random_key() : pool[i - 1] + 64'h400;
        for (int n = 0; n < POOL_ITEMS; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            op   = ohs_pkg::op_t'($urandom_range(0, 2));
            key  = pool[$urandom_range(0, POOL_SIZE - 1)];
            if (roll < 2)
            begin
                op  = ohs_pkg::OP_CLEAR;
                key = random_key();
            end
            else if (roll < 6)
                key = ohs_pkg::KEY_W'($urandom_range(0, 1));
            else if (roll < 16)
                key = random_key();
            send_request(op, key);
        end

        // --- fill every slot, then work the full table ---
        send_request(ohs_pkg::OP_CLEAR, random_key());
        while (tracker.empty_slots > 0)
        begin
            if (tracker.pending_replies.size() == 0 && $urandom_range(0, 99) == 0)
                steady = ~steady;
            roll = $urandom_range(0, 99);
            if (roll < 85 || members.size() == 0)
            begin
                key = random_key();
                members.push_back(key);
                send_request(ohs_pkg::OP_ADD, key);
            end
            else if (roll < 93)
                send_request(ohs_pkg::OP_CONTAINS,
                             roll[0] ? random_key() : members[$urandom_range(0, members.size() - 1)]);
            else
            begin
                idx = $urandom_range(0, members.size() - 1);
                key = members[idx];
                members.delete(idx);
                send_request(ohs_pkg::OP_REMOVE, key);
            end
        end
        steady = 1'b0;
        for (int n = 0; n < AFTER_FULL; n++)
        begin
            roll = $urandom_range(0, 99);
            idx  = $urandom_range(0, members.size() - 1);
            if (roll < 30)
                send_request(ohs_pkg::OP_ADD, random_key());      // table full
            else if (roll < 45)
                send_request(ohs_pkg::OP_ADD, members[idx]);
            else if (roll < 70)
                send_request(ohs_pkg::OP_CONTAINS, random_key()); // walks every slot
            else if (roll < 85)
                send_request(ohs_pkg::OP_CONTAINS, members[idx]);
            else
            begin
                key = members[idx];
                members.delete(idx);
                send_request(ohs_pkg::OP_REMOVE, key);
            end
        end
        send_request(ohs_pkg::OP_CLEAR, random_key());
        for (int n = 0; n < 10; n++)
            send_request(ohs_pkg::op_t'($urandom_range(0, 2)),
                         (n < 5) ? members[n] : random_key());

        // --- drain ---
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);   // catch any stray reply

        if (tracker.errors == 0)
            $display("** open_address_hash_set: PASSED **");
        else
            $display("** open_address_hash_set: FAILED **");
        $finish;
    end

endmodule
